@@ hdl/stack_engine_with_delete_filter_reverse_core_assert.svh @@
// Assertion helpers for the stack engine.
`ifndef STACK_ENGINE_WITH_DELETE_FILTER_REVERSE_CORE_ASSERT_SVH
`define STACK_ENGINE_WITH_DELETE_FILTER_REVERSE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SEFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SEFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sefr_pkg.sv @@
package sefr_pkg;

   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      REQ_PUSH      = 3'd0,
      REQ_POP       = 3'd1,
      REQ_DELETE    = 3'd2,
      REQ_DROP_EVEN = 3'd3,
      REQ_REVERSE   = 3'd4,
      REQ_CLEAR     = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } rsp_status_type;

   // datapath micro-operations
   typedef enum logic [4:0] {
      UOP_NONE, UOP_LOAD, UOP_PUSH_FULL, UOP_PUSH, UOP_POP_EMPTY, UOP_POP_RD,
      UOP_POP_TAKE, UOP_DEL_INIT, UOP_DEL_RD, UOP_IDX_DEC, UOP_SH_RD, UOP_SH_WR,
      UOP_DEL_DONE, UOP_DE_INIT, UOP_DE_RD, UOP_DE_EVAL, UOP_DE_DONE, UOP_RV_INIT,
      UOP_RV_RDA, UOP_RV_RDB, UOP_RV_WRA, UOP_RV_WRB, UOP_CLEAR, UOP_EMIT
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      req_code_type op;
      logic         empty;
      logic         full;
      logic         fill_le1;
      logic         match;
      logic         idx_one;
      logic         sh_more;
      logic         scan_done;
      logic         lo_lt_hi;
      logic         out_free;
   } dp_sts_type;

   typedef enum logic [14:0] {
      S_IDLE     = 15'h0001,
      S_DECODE   = 15'h0002,
      S_POP_WAIT = 15'h0004,
      S_DEL_RD   = 15'h0008,
      S_DEL_CMP  = 15'h0010,
      S_SH_CHK   = 15'h0020,
      S_SH_WR    = 15'h0040,
      S_DE_CHK   = 15'h0080,
      S_DE_EVAL  = 15'h0100,
      S_RV_CHK   = 15'h0200,
      S_RV_RDA   = 15'h0400,
      S_RV_RDB   = 15'h0800,
      S_RV_WRA   = 15'h1000,
      S_RV_WRB   = 15'h2000,
      S_FINISH   = 15'h4000
   } ctrl_state_type;

endpackage

@@ hdl/sefr_ctrl.sv @@
module sefr_ctrl
   import sefr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.uop    = UOP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.uop  = UOP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            case (sts.op)
               REQ_PUSH: begin
                  cmd.uop = sts.full ? UOP_PUSH_FULL : UOP_PUSH;
               end
               REQ_POP: begin
                  if (sts.empty) begin
                     cmd.uop = UOP_POP_EMPTY;
                  end else begin
                     cmd.uop  = UOP_POP_RD;
                     state_in = S_POP_WAIT;
                  end
               end
               REQ_DELETE: begin
                  cmd.uop = UOP_DEL_INIT;
                  if (!sts.empty) state_in = S_DEL_RD;
               end
               REQ_DROP_EVEN: begin
                  cmd.uop  = UOP_DE_INIT;
                  state_in = S_DE_CHK;
               end
               REQ_REVERSE: begin
                  if (!sts.fill_le1) begin
                     cmd.uop  = UOP_RV_INIT;
                     state_in = S_RV_CHK;
                  end
               end
               REQ_CLEAR: begin
                  cmd.uop = UOP_CLEAR;
               end
               default: begin
                  cmd.uop = UOP_NONE;
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.uop  = UOP_POP_TAKE;
            state_in = S_FINISH;
         end
         S_DEL_RD: begin
            cmd.uop  = UOP_DEL_RD;
            state_in = S_DEL_CMP;
         end
         S_DEL_CMP: begin
            if (sts.match) begin
               cmd.uop  = UOP_IDX_DEC;
               state_in = S_SH_CHK;
            end else if (sts.idx_one) begin
               state_in = S_FINISH;
            end else begin
               cmd.uop  = UOP_IDX_DEC;
               state_in = S_DEL_RD;
            end
         end
         S_SH_CHK: begin
            if (sts.sh_more) begin
               cmd.uop  = UOP_SH_RD;
               state_in = S_SH_WR;
            end else begin
               cmd.uop  = UOP_DEL_DONE;
               state_in = S_FINISH;
            end
         end
         S_SH_WR: begin
            cmd.uop  = UOP_SH_WR;
            state_in = S_SH_CHK;
         end
         S_DE_CHK: begin
            if (sts.scan_done) begin
               cmd.uop  = UOP_DE_DONE;
               state_in = S_FINISH;
            end else begin
               cmd.uop  = UOP_DE_RD;
               state_in = S_DE_EVAL;
            end
         end
         S_DE_EVAL: begin
            cmd.uop  = UOP_DE_EVAL;
            state_in = S_DE_CHK;
         end
         S_RV_CHK: begin
            if (sts.lo_lt_hi) begin
               cmd.uop  = UOP_RV_RDA;
               state_in = S_RV_RDB;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_RV_RDB: begin
            cmd.uop  = UOP_RV_RDB;
            state_in = S_RV_WRA;
         end
         S_RV_WRA: begin
            cmd.uop  = UOP_RV_WRA;
            state_in = S_RV_WRB;
         end
         S_RV_WRB: begin
            cmd.uop  = UOP_RV_WRB;
            state_in = S_RV_CHK;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.uop  = UOP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/sefr_dp.sv @@
module sefr_dp
   import sefr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_tuser,
   input  logic [WORD_W-1:0]     req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   req_code_type      op_ff, op_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [WORD_W-1:0] tmp_ff, tmp_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   rsp_status_type    res_status_ff, res_status_in;
   logic [WORD_W-1:0] res_popped_ff, res_popped_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_status_type    rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CW-1:0]     idx_m1, idx_p1, fill_m1;
   logic [CW:0]       idx_p1_wide;

   assign idx_m1      = idx_ff - 1'b1;
   assign idx_p1      = idx_ff + 1'b1;
   assign fill_m1     = fill_ff - 1'b1;
   assign idx_p1_wide = {1'b0, idx_ff} + 1'b1;

   always_comb begin
      sts.op        = op_ff;
      sts.empty     = (fill_ff == '0);
      sts.full      = (fill_ff == CW'(DEPTH));
      sts.fill_le1  = (fill_ff <= CW'(1));
      sts.match     = (rd_data_ff == val_ff);
      sts.idx_one   = (idx_ff == CW'(1));
      sts.sh_more   = (idx_p1_wide < {1'b0, fill_ff});
      sts.scan_done = (idx_ff == fill_ff);
      sts.lo_lt_hi  = (lo_ff < hi_ff);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // memory port control
   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      wr_addr = fill_ff[AW-1:0];
      wr_data = val_ff;
      wr_en   = 1'b0;
      case (cmd.uop)
         UOP_PUSH: begin
            wr_en = 1'b1;
         end
         UOP_POP_RD: rd_addr = fill_m1[AW-1:0];
         UOP_DEL_RD: rd_addr = idx_m1[AW-1:0];
         UOP_SH_RD:  rd_addr = idx_p1[AW-1:0];
         UOP_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         UOP_DE_RD:  rd_addr = idx_ff[AW-1:0];
         UOP_DE_EVAL: begin
            wr_en   = rd_data_ff[0];
            wr_addr = lo_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         UOP_RV_RDA: rd_addr = lo_ff[AW-1:0];
         UOP_RV_RDB: rd_addr = hi_ff[AW-1:0];
         UOP_RV_WRA: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         UOP_RV_WRB: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[AW-1:0];
            wr_data = tmp_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      tmp_in        = tmp_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      res_status_in = res_status_ff;
      res_popped_in = res_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (cmd.uop)
         UOP_LOAD: begin
            op_in         = req_code_type'(req_tuser);
            val_in        = req_tdata;
            res_status_in = ST_OK;
            res_popped_in = '0;
         end
         UOP_PUSH_FULL: res_status_in = ST_FULL;
         UOP_PUSH:      fill_in = fill_ff + 1'b1;
         UOP_POP_EMPTY: res_status_in = ST_EMPTY;
         UOP_POP_RD:    fill_in = fill_m1;
         UOP_POP_TAKE:  res_popped_in = rd_data_ff;
         UOP_DEL_INIT: begin
            res_status_in = ST_NOT_FOUND;
            idx_in        = fill_ff;
         end
         UOP_IDX_DEC:   idx_in = idx_m1;
         UOP_SH_WR:     idx_in = idx_p1;
         UOP_DEL_DONE: begin
            fill_in       = fill_m1;
            res_status_in = ST_OK;
         end
         UOP_DE_INIT: begin
            idx_in = '0;
            lo_in  = '0;
         end
         UOP_DE_EVAL: begin
            idx_in = idx_p1;
            if (rd_data_ff[0]) lo_in = lo_ff + 1'b1;
         end
         UOP_DE_DONE:   fill_in = lo_ff;
         UOP_RV_INIT: begin
            lo_in = '0;
            hi_in = fill_m1;
         end
         UOP_RV_RDB:    tmp_in = rd_data_ff;
         UOP_RV_WRB: begin
            lo_in = lo_ff + 1'b1;
            hi_in = hi_ff - 1'b1;
         end
         UOP_CLEAR:     fill_in = '0;
         UOP_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_popped_in = res_popped_ff;
            rsp_count_in  = COUNT_W'(fill_ff);
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      tmp_ff        <= tmp_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_status_ff <= res_status_in;
      res_popped_ff <= res_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_popped_ff};

endmodule

@@ hdl/stack_engine_with_delete_filter_reverse_core.sv @@
// Bounded LIFO stack engine of 32-bit words.
// Request channel (req_*): tuser carries the request code (push, pop, delete
// value, drop even entries, reverse, clear), tdata the operand value.
// Response channel (rsp_*): one item per request; tuser carries the status
// (ok, empty, not found, full), tdata the popped value and the entry count.
// Items are handled one at a time by a controller FSM driving a datapath
// with a single-port-write, registered-read word memory of DEPTH entries.
// Delete scans entries from the top and, on a hit, shifts the entries above
// it down; drop even scans every entry held; reverse swaps pairs from the
// ends inward. Each memory read or write is its own FSM step (one write
// port, registered read). The next request is taken the cycle after the
// response is loaded.
// The response sits in an output register; a new request is taken while an
// earlier response waits. If the receiver stalls, the finished result of the
// next request holds inside (req_tready low) until the register frees up.
// Reset clears the entry count and the response valid flag; the memory is
// not touched (only entries below the count are ever read).
`include "stack_engine_with_delete_filter_reverse_core_assert.svh"

module stack_engine_with_delete_filter_reverse_core
   import sefr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,  // [2:0] req_type
   input  logic [WORD_W-1:0]     req_tdata,  // [31:0] operand_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,  // [1:0] status
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [31:0] popped_value, [36:32] entry_count
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: one request at a time
   sefr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memory, pointers, result and output registers
   sefr_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // one request in flight: no accept right after an accept
   `SEFR_ASSERT_NXT(a_one_in_flight, clock, reset, req_tvalid && req_tready,
                    !req_tready, "request taken while busy")
   // a push that writes memory never happens on a full stack
   `SEFR_ASSERT_IMP(a_push_room, clock, reset, cmd.uop == UOP_PUSH,
                    !sts.full, "push into full stack")
   // a pop read never happens on an empty stack
   `SEFR_ASSERT_IMP(a_pop_data, clock, reset, cmd.uop == UOP_POP_RD,
                    !sts.empty, "pop from empty stack")
   // a result is only loaded when the output register is free
   `SEFR_ASSERT_IMP(a_emit_free, clock, reset, cmd.uop == UOP_EMIT,
                    sts.out_free, "response overwritten")

endmodule
